// ===== hdl/hmt_pkg.sv =====
// Shared types and constants for the hashed multiset table.
`timescale 1ns / 1ps

package hmt_pkg;

    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int TOTAL_W   = 16;
    localparam int OCC_W     = 16;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_COUNT  = 2'd3
    } hmt_cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } hmt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } hmt_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } hmt_stat_t;

endpackage

// ===== hdl/hash_multiset_table.sv =====
// Top level of the hashed multiset table.
`timescale 1ns / 1ps

// Bag of signed 32-bit values in BUCKETS rows of WAYS ways; a request is
// {value, cmd} (add, remove one copy, search, count) and each request gives
// one result. On accept the request's row is read from the row memories into
// read registers; on commit all ways are compared, the row is written back and
// the result register is loaded. The next request is accepted in the cycle
// after a commit, even while the previous result still waits; its commit then
// holds until the result register is free or being drained, and no further
// request is taken meanwhile. After reset the block sweeps the multiplicity
// rows to zero, one row a cycle, before it accepts the first request.
// BUCKETS must be a power of two; an add that finds no free way, or would
// saturate a counter, is refused and flagged.
module hash_multiset_table #(
    parameter int BUCKETS    = 64,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd[1:0], value[33:2], zero[39:34]
    input  logic [hmt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found[0], occurrences[16:1], bag_size[32:17], bag_empty[33], refused[34], zero[39:35]
    output logic [hmt_pkg::M_TDATA_W-1:0]     m_tdata
);
    import hmt_pkg::*;

    hmt_ctl_t  ctl;
    hmt_stat_t stat;

    logic               found;
    logic [OCC_W-1:0]   occurrences;
    logic [TOTAL_W-1:0] bag_size;
    logic               bag_empty;
    logic               refused;

    hmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    hmt_dpath #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .stat            (stat),
        .in_cmd          (s_tdata[CMD_W-1:0]),
        .in_value        (s_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_found       (found),
        .out_occurrences (occurrences),
        .out_bag_size    (bag_size),
        .out_bag_empty   (bag_empty),
        .out_refused     (refused)
    );

    assign m_tdata = {5'b0, refused, bag_empty, bag_size, occurrences, found};

endmodule

// ===== hdl/hmt_ctrl.sv =====
// Sequencer for the hashed multiset table: clear sweep, accept, commit.
`timescale 1ns / 1ps

module hmt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  hmt_pkg::hmt_stat_t stat,
    output hmt_pkg::hmt_ctl_t  ctl
);
    import hmt_pkg::*;

    hmt_state_t state_reg;
    hmt_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctl.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold the row until the result register is free
                if (!stat.out_busy) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/hmt_dpath.sv =====
// Row memories, way compare, update logic and result register.
`timescale 1ns / 1ps

module hmt_dpath #(
    parameter int BUCKETS    = 64,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hmt_pkg::hmt_ctl_t              ctl,
    output hmt_pkg::hmt_stat_t             stat,
    input  logic [hmt_pkg::CMD_W-1:0]      in_cmd,
    input  logic signed [hmt_pkg::VALUE_W-1:0] in_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_found,
    output logic [hmt_pkg::OCC_W-1:0]      out_occurrences,
    output logic [hmt_pkg::TOTAL_W-1:0]    out_bag_size,
    output logic                           out_bag_empty,
    output logic                           out_refused
);
    import hmt_pkg::*;

    localparam int RB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [WAYS-1:0][COUNT_BITS-1:0] mult_row_t;
    typedef logic [WAYS-1:0][VALUE_W-1:0]    val_row_t;

    mult_row_t mult_mem [BUCKETS];
    val_row_t  val_mem  [BUCKETS];

    mult_row_t          mult_rd_reg;
    val_row_t           val_rd_reg;
    logic [RB-1:0]      row_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [RB-1:0]      clr_cnt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    logic               out_valid_reg;
    logic               found_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic               refused_reg;

    logic [RB-1:0]      in_row;

    logic               hit_any;
    logic [WB-1:0]      hit_idx;
    logic               free_any;
    logic [WB-1:0]      free_idx;
    logic [COUNT_BITS-1:0] occ_cur;
    logic [COUNT_BITS-1:0] occ_new;
    logic [OCC_W-1:0]   occ_next;
    logic               found_next;
    logic               refused_next;
    logic               mult_we;
    logic               val_we;
    mult_row_t          mult_wr;
    val_row_t           val_wr;

    // Row is the magnitude modulo BUCKETS; the low bits of -v are -(low bits of v).
    assign in_row = in_value[VALUE_W-1] ? (RB'(0) - in_value[RB-1:0]) : in_value[RB-1:0];

    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        // scan downwards so the lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (mult_rd_reg[w] != '0) begin
                if (val_rd_reg[w] == value_reg) begin
                    hit_any = 1'b1;
                    hit_idx = WB'(w);
                end
            end else begin
                free_any = 1'b1;
                free_idx = WB'(w);
            end
        end
    end

    assign occ_cur = hit_any ? mult_rd_reg[hit_idx] : '0;

    always_comb begin
        occ_new      = occ_cur;
        found_next   = 1'b0;
        refused_next = 1'b0;
        total_next   = total_reg;
        mult_we      = 1'b0;
        val_we       = 1'b0;
        mult_wr      = mult_rd_reg;
        val_wr       = val_rd_reg;
        unique case (hmt_cmd_t'(cmd_reg))
            CMD_ADD: begin
                priority if (total_reg == '1) begin
                    refused_next = 1'b1;
                end else if (hit_any) begin
                    if (occ_cur == '1) begin
                        refused_next = 1'b1;
                    end else begin
                        occ_new          = occ_cur + 1'b1;
                        mult_wr[hit_idx] = occ_cur + 1'b1;
                        mult_we          = 1'b1;
                        total_next       = total_reg + 1'b1;
                        found_next       = 1'b1;
                    end
                end else if (free_any) begin
                    occ_new           = COUNT_BITS'(1);
                    mult_wr[free_idx] = COUNT_BITS'(1);
                    val_wr[free_idx]  = value_reg;
                    mult_we           = 1'b1;
                    val_we            = 1'b1;
                    total_next        = total_reg + 1'b1;
                    found_next        = 1'b1;
                end else begin
                    refused_next = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (hit_any) begin
                    occ_new          = occ_cur - 1'b1;
                    mult_wr[hit_idx] = occ_cur - 1'b1;
                    mult_we          = 1'b1;
                    if (total_reg != '0) begin
                        total_next = total_reg - 1'b1;
                    end
                    found_next = 1'b1;
                end
            end
            CMD_SEARCH, CMD_COUNT: begin
                found_next = hit_any;
            end
            default: begin
                found_next = hit_any;
            end
        endcase
    end

    generate
        if (COUNT_BITS > OCC_W) begin : g_sat
            assign occ_next = (|occ_new[COUNT_BITS-1:OCC_W]) ? '1 : occ_new[OCC_W-1:0];
        end else begin : g_ext
            assign occ_next = OCC_W'(occ_new);
        end
    endgenerate

    // Memories: clear sweep over the multiplicity rows, read on accept, write on commit
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            mult_mem[clr_cnt_reg] <= '0;
        end else if (ctl.commit && mult_we) begin
            mult_mem[row_reg] <= mult_wr;
        end
        if (ctl.accept) begin
            mult_rd_reg <= mult_mem[in_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit && val_we) begin
            val_mem[row_reg] <= val_wr;
        end
        if (ctl.accept) begin
            val_rd_reg <= val_mem[in_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            row_reg   <= in_row;
            cmd_reg   <= in_cmd;
            value_reg <= in_value;
        end
        if (ctl.commit) begin
            found_reg   <= found_next;
            occ_reg     <= occ_next;
            refused_reg <= refused_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctl.commit) begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == RB'(BUCKETS - 1));
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign out_found       = found_reg;
    assign out_occurrences = occ_reg;
    assign out_bag_size    = total_reg;
    assign out_bag_empty   = (total_reg == '0);
    assign out_refused     = refused_reg;

endmodule

// ===== hdl/hmt_checker.sv =====
// Port-level checks for the hashed multiset table, bound to the top level.
`timescale 1ns / 1ps

module hmt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [hmt_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hmt_pkg::M_TDATA_W-1:0] m_tdata
);
    import hmt_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33] == (m_tdata[32:17] == 16'd0)))
        else $error("bag_empty disagrees with bag_size");

    a_refused_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> !m_tdata[0])
        else $error("refused request reported as found");

    // one request at a time: row read then commit
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted in back-to-back cycles");

endmodule

bind hash_multiset_table hmt_checker u_hmt_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the hashed multiset table.
`timescale 1ns / 1ps

module tb_top;
    import hmt_pkg::*;

    localparam int BUCKETS    = 64;
    localparam int WAYS       = 4;
    localparam int COUNT_BITS = 16;
    localparam int SLOTS      = BUCKETS * WAYS;
    localparam logic [OCC_W-1:0]   MULT_MAX  = OCC_W'((64'd1 << COUNT_BITS) - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic               found;
        logic [OCC_W-1:0]   occurrences;
        logic [TOTAL_W-1:0] bag_size;
        logic               bag_empty;
        logic               refused;
    } bag_result_t;

    typedef struct packed {
        hmt_cmd_t         cmd;
        logic [31:0]      value;
        logic             fixed;
        bag_result_t      res;
    } dir_row_t;

    localparam bag_result_t NO_RES = '0;
    localparam int DIR_ROWS = 25;

    // columns: cmd, value, fixed, {found, occurrences, bag_size, bag_empty, refused}
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{CMD_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0}},
        '{CMD_COUNT,  32'h7FFF_FFFF, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0}},
        '{CMD_REMOVE, 32'h8000_0000, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0}},
        '{CMD_ADD,    32'h8000_0000, 1'b1, '{1'b1, 16'd1, 16'd1, 1'b0, 1'b0}},
        '{CMD_ADD,    32'h0000_0000, 1'b1, '{1'b1, 16'd1, 16'd2, 1'b0, 1'b0}},
        '{CMD_ADD,    32'h0000_0040, 1'b0, NO_RES},
        '{CMD_ADD,    32'hFFFF_FFC0, 1'b0, NO_RES},
        '{CMD_ADD,    32'h0000_0080, 1'b1, '{1'b0, 16'd0, 16'd4, 1'b0, 1'b1}},
        '{CMD_ADD,    32'h0000_0000, 1'b0, NO_RES},
        '{CMD_SEARCH, 32'hFFFF_FFC0, 1'b0, NO_RES},
        '{CMD_COUNT,  32'h0000_0080, 1'b0, NO_RES},
        '{CMD_REMOVE, 32'h0000_0040, 1'b0, NO_RES},
        '{CMD_ADD,    32'h0000_0080, 1'b0, NO_RES},
        '{CMD_COUNT,  32'h0000_0000, 1'b0, NO_RES},
        '{CMD_ADD,    32'h7FFF_FFFF, 1'b0, NO_RES},
        '{CMD_ADD,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{CMD_ADD,    32'h0000_0001, 1'b0, NO_RES},
        '{CMD_ADD,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{CMD_COUNT,  32'hFFFF_FFFF, 1'b0, NO_RES},
        '{CMD_SEARCH, 32'h0000_0001, 1'b0, NO_RES},
        '{CMD_REMOVE, 32'h8000_0000, 1'b0, NO_RES},
        '{CMD_REMOVE, 32'h8000_0000, 1'b0, NO_RES},
        '{CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
        '{CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
        '{CMD_SEARCH, 32'h0000_0000, 1'b0, NO_RES}
    };

    // rows that collect most of the random traffic, so that ways run out
    localparam logic [31:0] HOT_ROWS [4] = '{32'd0, 32'd1, 32'd33, 32'd63};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // typed expectation travelling alongside the request on the bus
    logic        s_fixed;
    bag_result_t s_fixed_res;

    logic [31:0]        bag_val  [SLOTS];
    logic [OCC_W-1:0]   bag_mult [SLOTS];
    logic [TOTAL_W-1:0] bag_total;

    bag_result_t pending_results [$];
    int          mismatches;
    int          cycles;
    bit          quiet_tail;
    bit          send_gaps;
    bit          stall_on;

    hash_multiset_table #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one request to the local copy of the bag and return its result.
    function automatic bag_result_t bag_apply(input hmt_cmd_t cmd, input logic [31:0] v);
        bag_result_t      r;
        logic [31:0]      mag;
        logic [OCC_W-1:0] occ;
        int               base;
        int               hit;
        int               free_way;
        r        = '0;
        mag      = v[31] ? (~v + 32'd1) : v;
        base     = int'(mag % BUCKETS) * WAYS;
        hit      = -1;
        free_way = -1;
        occ      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (bag_mult[base + w] != '0) begin
                if (hit < 0 && bag_val[base + w] == v)
                    hit = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (hit >= 0)
            occ = bag_mult[base + hit];
        case (cmd)
            CMD_ADD: begin
                if (bag_total >= TOTAL_MAX) begin
                    r.refused = 1'b1;
                end else if (hit >= 0) begin
                    if (occ >= MULT_MAX) begin
                        r.refused = 1'b1;
                    end else begin
                        occ                 = occ + 1'b1;
                        bag_mult[base + hit] = occ;
                        bag_total           = bag_total + 1'b1;
                        r.found             = 1'b1;
                    end
                end else if (free_way >= 0) begin
                    bag_val[base + free_way]  = v;
                    bag_mult[base + free_way] = OCC_W'(1);
                    occ                       = OCC_W'(1);
                    bag_total                 = bag_total + 1'b1;
                    r.found                   = 1'b1;
                end else begin
                    r.refused = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    occ                  = occ - 1'b1;
                    bag_mult[base + hit] = occ;
                    if (bag_total != '0)
                        bag_total = bag_total - 1'b1;
                    r.found = 1'b1;
                end
            end
            CMD_SEARCH, CMD_COUNT: begin
                r.found = (occ != '0);
            end
        endcase
        r.occurrences = occ;
        r.bag_size    = bag_total;
        r.bag_empty   = (bag_total == '0);
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            mag = HOT_ROWS[$urandom_range(0, 3)] + 32'(BUCKETS * $urandom_range(0, 5));
            return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
        end else if (sel == 6) begin
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return $urandom();
    endfunction

    function automatic hmt_cmd_t pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CMD_ADD;
        else if (r < 70)
            return CMD_REMOVE;
        else if (r < 85)
            return CMD_SEARCH;
        return CMD_COUNT;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic send_request(input hmt_cmd_t cmd, input logic [31:0] v,
                                input logic fixed, input bag_result_t res);
        if (!quiet_tail && send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {{(S_TDATA_W - 34){1'b0}}, v, cmd};
        s_fixed     <= fixed;
        s_fixed_res <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Predict on each accepted request, check each accepted result in order.
    bag_result_t got_res;
    bag_result_t want_res;
    bag_result_t pred_res;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_res.found       = m_tdata[0];
                got_res.occurrences = m_tdata[16:1];
                got_res.bag_size    = m_tdata[32:17];
                got_res.bag_empty   = m_tdata[33];
                got_res.refused     = m_tdata[34];
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
                end else begin
                    want_res = pending_results.pop_front();
                    check_field("found", want_res.found, got_res.found);
                    check_field("occurrences", want_res.occurrences, got_res.occurrences);
                    check_field("bag_size", want_res.bag_size, got_res.bag_size);
                    check_field("bag_empty", want_res.bag_empty, got_res.bag_empty);
                    check_field("refused", want_res.refused, got_res.refused);
                end
            end
            if (s_tvalid && s_tready) begin
                pred_res = bag_apply(hmt_cmd_t'(s_tdata[1:0]), s_tdata[33:2]);
                pending_results.push_back(s_fixed ? s_fixed_res : pred_res);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stall bursts, switched on and off in stretches.
    initial begin
        m_tready = 1'b0;
        stall_on = 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 63) == 0)
                stall_on = ~stall_on;
            if (!quiet_tail && stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_fixed     = 1'b0;
        s_fixed_res = NO_RES;
        mismatches  = 0;
        cycles      = 0;
        quiet_tail  = 1'b0;
        send_gaps   = 1'b1;
        bag_total   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            bag_val[i]  = '0;
            bag_mult[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].fixed,
                         DIRECTED[i].res);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0)
                send_gaps = $urandom_range(0, 1);
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            send_request(pick_cmd(), pick_value(), 1'b0, NO_RES);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
